@@ design/ubps_pkg.sv @@
// Package for the unique byte pattern search core.
// Holds the sizes, the status and register codes, and the request type between stages.
// No dependencies.
package ubps_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 32;
  localparam int PAT_REG_WORDS = 4;
  localparam int PAT_REG_BYTES = PAT_REG_WORDS * 8;
  localparam int PAT_REG_BITS  = PAT_REG_BYTES * 8;
  localparam int LEN_W         = 6;
  localparam int LEN_EFF_W     = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int COUNT_W       = 16;
  localparam int OFFSET_W      = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_UNIQUE = 2'd1,
    STATUS_MULTI  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD0  = 3'd0,
    REG_WORD1  = 3'd1,
    REG_WORD2  = 3'd2,
    REG_WORD3  = 3'd3,
    REG_LENGTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     hit;
    logic [POSITION_BITS-1:0] offset;
  } tally_req_t;

  function automatic logic [7:0] pattern_byte(input logic [PAT_REG_BITS-1:0] pat,
                                              input int k);
    logic [7:0] b;
    b = 8'd0;
    if (k < PAT_REG_BYTES) begin
      b = pat[k*8 +: 8];
    end
    return b;
  endfunction

endpackage

@@ design/ubps_in_if.sv @@
// Input byte channel of the pattern search core.
// Has no dependencies.
interface ubps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/ubps_out_if.sv @@
// Result channel of the pattern search core.
// Depends on ubps_pkg.
interface ubps_out_if;
  import ubps_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          search_status;
  logic [OFFSET_W-1:0] match_offset;
  logic [COUNT_W-1:0]  match_total;

  modport source (output valid, output search_status, output match_offset,
                  output match_total, input ready);
  modport sink (input valid, input search_status, input match_offset,
                input match_total, output ready);
endinterface

@@ design/ubps_cfg_if.sv @@
// Register write channel of the pattern search core.
// Depends on ubps_pkg.
interface ubps_cfg_if;
  import ubps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/ubps_cell.sv @@
// One cell of the match chain: it records whether pattern bytes 0 to k matched
// the stream ending at the newest byte. Depends on ubps_pkg.
module ubps_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       restart,
  input  logic       prev_hit,
  input  logic [7:0] data_byte,
  input  logic [7:0] pat_byte,
  output logic       hit_r
);
  import ubps_pkg::*;

  logic hit_nxt;

  assign hit_nxt = prev_hit && !restart && (data_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (shift_en) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

@@ design/ubps_tally.sv @@
// Match counter, latest offset and result register of the pattern search core.
// Depends on ubps_pkg and ubps_out_if.
module ubps_tally (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ubps_pkg::tally_req_t   req,
  output logic                   advance,
  ubps_out_if.source             out_ch
);
  import ubps_pkg::*;

  logic [COUNT_W-1:0]       cnt_r;
  logic [COUNT_W-1:0]       cnt_inc;
  logic [COUNT_W-1:0]       cnt_nxt;
  logic [POSITION_BITS-1:0] off_r;
  logic [POSITION_BITS-1:0] off_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  status_t                  status_r;
  status_t                  status_nxt;
  logic [OFFSET_W-1:0]      out_off_r;
  logic [COUNT_W-1:0]       out_total_r;
  logic                     finish;

  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_W'(1);
  assign cnt_nxt = req.hit ? cnt_inc : cnt_r;
  assign off_nxt = req.hit ? req.offset : off_r;
  assign advance = !(req.valid && req.last && out_valid_r && !out_ch.ready);
  assign finish  = req.valid && req.last && advance;
  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || finish;

  always_comb begin
    if (cnt_nxt == '0) begin
      status_nxt = STATUS_NONE;
    end else if (cnt_nxt == COUNT_W'(1)) begin
      status_nxt = STATUS_UNIQUE;
    end else begin
      status_nxt = STATUS_MULTI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (req.valid && advance) begin
        if (req.last) begin
          cnt_r <= '0;
          off_r <= '0;
        end else begin
          cnt_r <= cnt_nxt;
          off_r <= off_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status_r    <= status_nxt;
      out_off_r   <= OFFSET_W'(off_nxt);
      out_total_r <= cnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.search_status = status_r;
  assign out_ch.match_offset  = out_off_r;
  assign out_ch.match_total   = out_total_r;

  a_zero_count_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (off_r == '0))
    else $error("offset held without a counted match");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(req.valid && req.last))
    else $error("result raised without a final byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> (out_valid_r && req.valid && req.last))
    else $error("tally stalled without a pending result");

endmodule

@@ design/unique_byte_pattern_search_core.sv @@
// Unique byte pattern search core: top level with registers, cell chain and tally.
// Depends on ubps_pkg, the three channel interfaces, ubps_cell and ubps_tally.
//
// The core takes one byte per clock cycle. Each cell of a row of MAX_PATTERN cells
// keeps a prefix-match bit and passes it to its neighbor on every accepted byte,
// so all pattern compares run in parallel. After an image's last byte is accepted,
// its result passes stage one into the output register. The input stalls only
// while a result waits unclaimed there and the next image's last byte is at the
// tally. The user writes registers only while idle; the core does not enforce it.
module unique_byte_pattern_search_core (
  input  logic       clk,
  input  logic       rst_n,
  ubps_in_if.sink    in_ch,
  ubps_out_if.source out_ch,
  ubps_cfg_if.sink   cfg_ch
);
  import ubps_pkg::*;

  logic [PAT_REG_BITS-1:0]  pat_r;
  logic [LEN_W-1:0]         len_r;
  logic [LEN_EFF_W-1:0]     len_eff;
  logic [LEN_EFF_W-1:0]     len_m1;
  logic [MAX_PATTERN-1:0]   match_vec;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     restart_r;
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic [POSITION_BITS-1:0] s1_pos_r;
  logic                     advance;
  logic                     accept;
  tally_req_t               req;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= LEN_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_WORD0:  pat_r[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_ch.data;
        REG_WORD1:  pat_r[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_ch.data;
        REG_WORD2:  pat_r[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_ch.data;
        REG_WORD3:  pat_r[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_ch.data;
        REG_LENGTH: len_r <= cfg_ch.data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev_hit;
    logic cell_restart;
    if (k == 0) begin : g_head
      assign prev_hit     = 1'b1;
      assign cell_restart = 1'b0;
    end else begin : g_body
      assign prev_hit     = match_vec[k-1];
      assign cell_restart = restart_r;
    end
    ubps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (accept),
      .restart   (cell_restart),
      .prev_hit  (prev_hit),
      .data_byte (in_ch.data_byte),
      .pat_byte  (pattern_byte(pat_r, k)),
      .hit_r     (match_vec[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      restart_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_r <= accept;
      end
      if (accept) begin
        restart_r <= in_ch.last_byte;
        pos_r     <= in_ch.last_byte ? '0 : pos_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_ch.last_byte;
      s1_pos_r  <= pos_r;
    end
  end

  assign len_eff = (int'(len_r) > MAX_PATTERN) ? LEN_EFF_W'(MAX_PATTERN) : LEN_EFF_W'(len_r);
  assign len_m1  = len_eff - LEN_EFF_W'(1);

  always_comb begin
    req.valid  = s1_valid_r;
    req.last   = s1_last_r;
    req.hit    = s1_valid_r && (len_eff != '0) && match_vec[IDX_W'(len_m1)];
    req.offset = s1_pos_r - POSITION_BITS'(len_m1);
  end

  ubps_tally u_tally (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .advance (advance),
    .out_ch  (out_ch)
  );

  a_pos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_byte) |=> (pos_r == '0 && restart_r))
    else $error("stream position not restarted after final byte");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_pos_r) && $stable(match_vec)))
    else $error("stage one changed while stalled");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with an empty result register");

endmodule
